>>> rtl/wss_pkg.sv
// Package: register map, search mode codes and pattern helpers for the substring search core.
package wss_pkg;

    // Register indexes on the configuration port (8-byte stride)
    localparam logic [2:0] REG_PATTERN_BYTES  = 3'd0;
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [2:0] REG_SEARCH_MODE    = 3'd2;
    localparam logic [2:0] REG_WINDOW_START   = 3'd3;
    localparam logic [2:0] REG_WINDOW_END     = 3'd4;
    localparam logic [2:0] REG_TEXT_LENGTH    = 3'd5;

    // Search modes
    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_RFIND  = 2'd1;
    localparam logic [1:0] MODE_COUNT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Fixed field widths
    localparam int PATTERN_W = 64;
    localparam int POS_W     = 17;
    localparam int COUNT_W   = 16;
    localparam int SIZE_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [PATTERN_W-1:0] pattern_t;
    typedef logic [7:0]           char_t;

    // Pick pattern character j; characters past the eighth are zero
    function automatic char_t pattern_byte(input pattern_t pat, input logic [3:0] j);
        char_t b;
        b = 8'h00;
        if (j < 4'd8)
        begin
            b = pat[{j[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

>>> rtl/windowed_substring_search_core.sv
// Top level: streaming windowed substring search (find, rfind, count) with APB configuration.
// Result: the output register is loaded by the final byte; the result appears in the cycle after it is accepted.
// Throughput: one text byte per cycle when not stalled; the compare and stream-state update are combinational.
// Input stalls only while a held result is not taken; any beat waits then, final or not.
// Reset: rst_n clears configuration to its defaults and the stream state but the byte history; no clearing pass.
module windowed_substring_search_core #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Text input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        is_final,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [16:0] match_position,
    output logic [15:0] match_count,
    output logic        found
);

    localparam int IDXW = $clog2(MAX_TEXT + 1);
    localparam int AW   = ((IDXW > wss_pkg::SIZE_W) ? IDXW : wss_pkg::SIZE_W) + 3;

    // Configuration registers
    wss_pkg::pattern_t                 pattern_bytes_reg;
    logic [3:0]                        pattern_length_reg;
    logic [1:0]                        search_mode_reg;
    logic [wss_pkg::POS_W-1:0]         window_start_reg;
    logic [wss_pkg::POS_W-1:0]         window_end_reg;
    logic [wss_pkg::SIZE_W-1:0]        text_length_reg;

    // Stream state
    wss_pkg::char_t                    recent_bytes_reg [MAX_PATTERN];
    wss_pkg::char_t                    recent_bytes_next [MAX_PATTERN];
    logic [IDXW-1:0]                   byte_index_reg;
    logic [IDXW-1:0]                   byte_index_next;
    logic signed [wss_pkg::POS_W-1:0]  best_position_reg;
    logic signed [wss_pkg::POS_W-1:0]  best_position_next;
    logic [wss_pkg::COUNT_W-1:0]       occurrences_reg;
    logic [wss_pkg::COUNT_W-1:0]       occurrences_next;
    logic [wss_pkg::SIZE_W-1:0]        blocked_until_reg;
    logic [wss_pkg::SIZE_W-1:0]        blocked_until_next;

    // Result register
    logic                              out_valid_reg;
    logic signed [wss_pkg::POS_W-1:0]  match_position_reg;
    logic [wss_pkg::COUNT_W-1:0]       match_count_reg;
    logic                              found_reg;

    logic                              cfg_write;
    logic                              in_fire;
    logic [1:0]                        mode_eff;
    logic [3:0]                        len_eff;
    logic                              hit;

    logic signed [AW-1:0] idx_s;
    logic signed [AW-1:0] size_s;
    logic signed [AW-1:0] rs_s;
    logic signed [AW-1:0] re_s;
    logic signed [AW-1:0] start_sum;
    logic signed [AW-1:0] end_sum;
    logic signed [AW-1:0] start_s;
    logic signed [AW-1:0] end_s;
    logic signed [AW-1:0] hi_s;
    logic signed [AW-1:0] len_s;
    logic signed [AW-1:0] pos_s;
    logic signed [AW-1:0] pos_end_s;
    logic signed [AW-1:0] blocked_s;
    logic                 eligible;
    logic                 count_ok;
    logic                 find_ok;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= 4'd1;
            search_mode_reg    <= wss_pkg::MODE_FIND;
            window_start_reg   <= '0;
            window_end_reg     <= '1;
            text_length_reg    <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                wss_pkg::REG_PATTERN_BYTES:  pattern_bytes_reg  <= pwdata;
                wss_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[3:0];
                wss_pkg::REG_SEARCH_MODE:    search_mode_reg    <= pwdata[1:0];
                wss_pkg::REG_WINDOW_START:   window_start_reg   <= pwdata[16:0];
                wss_pkg::REG_WINDOW_END:     window_end_reg     <= pwdata[16:0];
                wss_pkg::REG_TEXT_LENGTH:    text_length_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[5:3])
            wss_pkg::REG_PATTERN_BYTES:  prdata = pattern_bytes_reg;
            wss_pkg::REG_PATTERN_LENGTH: prdata = {60'd0, pattern_length_reg};
            wss_pkg::REG_SEARCH_MODE:    prdata = {62'd0, search_mode_reg};
            wss_pkg::REG_WINDOW_START:   prdata = {47'd0, window_start_reg};
            wss_pkg::REG_WINDOW_END:     prdata = {47'd0, window_end_reg};
            wss_pkg::REG_TEXT_LENGTH:    prdata = {48'd0, text_length_reg};
            default:                     prdata = 64'd0;
        endcase
    end

    // Clamp pattern length and fold the unused mode onto find
    always_comb
    begin
        mode_eff = (search_mode_reg == wss_pkg::MODE_UNUSED) ? wss_pkg::MODE_FIND
                                                             : search_mode_reg;
        len_eff = pattern_length_reg;
        if (pattern_length_reg == 4'd0)
        begin
            len_eff = 4'd1;
        end
        else if (int'(pattern_length_reg) > MAX_PATTERN)
        begin
            len_eff = 4'(MAX_PATTERN);
        end
    end

    // Shift the new byte into the history line
    always_comb
    begin
        recent_bytes_next[0] = text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            recent_bytes_next[k] = recent_bytes_reg[k-1];
        end
    end

    // Compare each active tap against its pattern character
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k < int'(len_eff))
            begin
                if (recent_bytes_next[k] !=
                    wss_pkg::pattern_byte(pattern_bytes_reg, 4'(int'(len_eff) - 1 - k)))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    // Normalize the window against the text size
    assign idx_s     = AW'($signed({1'b0, byte_index_reg}));
    assign size_s    = AW'($signed({1'b0, text_length_reg}));
    assign rs_s      = AW'($signed(window_start_reg));
    assign re_s      = AW'($signed(window_end_reg));
    assign start_sum = size_s + rs_s;
    assign end_sum   = size_s + re_s + AW'(1);
    assign len_s     = AW'($signed({1'b0, len_eff}));
    assign pos_s     = idx_s + AW'(1) - len_s;
    assign pos_end_s = pos_s + len_s;
    assign blocked_s = AW'($signed({1'b0, blocked_until_reg}));

    always_comb
    begin
        if (rs_s < 0)
        begin
            start_s = (start_sum < 0) ? '0 : start_sum;
        end
        else
        begin
            start_s = rs_s;
        end
        if (re_s < 0)
        begin
            end_s = (end_sum < 0) ? '0 : end_sum;
        end
        else
        begin
            end_s = re_s;
        end
        hi_s = (end_s < size_s) ? end_s : size_s;
    end

    // Qualify the match for each mode
    assign eligible = (idx_s < size_s) && (pos_s >= 0) && hit;
    assign count_ok = (rs_s <= size_s) && (pos_s >= start_s) && (pos_s < end_s)
                      && (pos_s >= blocked_s);
    assign find_ok  = (start_s <= size_s) && (end_s > start_s) && (pos_s >= start_s)
                      && (pos_end_s <= hi_s);

    // Update stream state for the accepted beat
    always_comb
    begin
        best_position_next = best_position_reg;
        occurrences_next   = occurrences_reg;
        blocked_until_next = blocked_until_reg;
        byte_index_next    = byte_index_reg;
        if (byte_index_reg < IDXW'(MAX_TEXT))
        begin
            byte_index_next = byte_index_reg + IDXW'(1);
        end
        if (eligible)
        begin
            if (mode_eff == wss_pkg::MODE_COUNT)
            begin
                if (count_ok)
                begin
                    if (occurrences_reg != wss_pkg::COUNT_MAX)
                    begin
                        occurrences_next = occurrences_reg + 16'd1;
                    end
                    blocked_until_next = pos_end_s[wss_pkg::SIZE_W-1:0];
                end
            end
            else if (find_ok)
            begin
                if ((mode_eff == wss_pkg::MODE_RFIND) || best_position_reg[16])
                begin
                    best_position_next = pos_s[wss_pkg::POS_W-1:0];
                end
            end
        end
    end

    // Hold stream state; clear it after the final beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            best_position_reg <= '1;
            occurrences_reg   <= '0;
            blocked_until_reg <= '0;
        end
        else if (in_fire)
        begin
            if (is_final)
            begin
                byte_index_reg    <= '0;
                best_position_reg <= '1;
                occurrences_reg   <= '0;
                blocked_until_reg <= '0;
            end
            else
            begin
                byte_index_reg    <= byte_index_next;
                best_position_reg <= best_position_next;
                occurrences_reg   <= occurrences_next;
                blocked_until_reg <= blocked_until_next;
            end
        end
    end

    // Advance the history line; only bytes of the current text are compared
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                recent_bytes_reg[k] <= recent_bytes_next[k];
            end
        end
    end

    // Result valid: load on a final beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && is_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire && is_final)
        begin
            if (mode_eff == wss_pkg::MODE_COUNT)
            begin
                match_position_reg <= '1;
                match_count_reg    <= occurrences_next;
                found_reg          <= (occurrences_next != '0);
            end
            else
            begin
                match_position_reg <= best_position_next;
                match_count_reg    <= '0;
                found_reg          <= !best_position_next[16];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_position = match_position_reg;
    assign match_count    = match_count_reg;
    assign found          = found_reg;

`ifndef SYNTHESIS
    // A final beat always produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && is_final) |=> out_valid)
        else $error("final beat did not produce a result");

    // A final beat clears the stream position
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && is_final) |=> (byte_index_reg == '0)
            && best_position_reg[16])
        else $error("stream state not cleared after final beat");

    // Found matches either a position or a nonzero count, never neither
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (!match_position[16] || (match_count != '0)))
        else $error("found flag without position or count");

    // A reported position never comes with a count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !match_position[16]) |-> (match_count == '0) && found)
        else $error("position and count reported together");
`endif

endmodule
